[hw/rtl/csc_pkg.sv]
// Channel range scaler package: request/response structs, range entry,
// command, status and channel kind codes, controller states.
// No dependencies.
`default_nettype none

package csc_pkg;

	localparam logic [1:0] CMD_SET       = 2'd0;
	localparam logic [1:0] CMD_SCALE_OUT = 2'd1;
	localparam logic [1:0] CMD_SCALE_IN  = 2'd2;
	localparam logic [1:0] CMD_NONE      = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAN = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_TYPE     = 2'd3;

	localparam logic [1:0] TY_NONE = 2'd0;
	localparam logic [1:0] TY_UNI  = 2'd1;
	localparam logic [1:0] TY_BI   = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic               table_sel;
		logic [3:0]         channel;
		logic [1:0]         new_type;
		logic [15:0]        new_min;
		logic [15:0]        new_max;
		logic signed [15:0] norm_value;
		logic [15:0]        pulse_in;
	} csc_in_t;

	typedef struct packed {
		logic [15:0]        pulse_out;
		logic signed [15:0] norm_out;
		logic [1:0]         status;
	} csc_out_t;

	typedef struct packed {
		logic [1:0]  ty;
		logic [15:0] mn;
		logic [15:0] mx;
	} csc_ent_t;

	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [15:0] divisor;
	} csc_div_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_EVAL,
		S_MUL,
		S_SUM,
		S_DIV,
		S_DONE
	} csc_state_t;

endpackage

`default_nettype wire

[hw/rtl/csc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module csc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                       wdata,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/csc_div.sv]
// Radix-2 restoring divider for pulse normalization, one quotient bit per cycle.
// Depends on csc_pkg.
`default_nettype none

module csc_div import csc_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  csc_div_op_t         op,
	output logic                done,
	output logic [FRAC_BITS+1:0] quot
);

	localparam int QW = FRAC_BITS + 2;
	localparam int CW = $clog2(FRAC_BITS + 2);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [15:0]   rem_q;
	logic [15:0]   divisor_q;
	logic [QW-1:0] quot_q;

	logic [16:0] rem2;
	logic        take;
	logic [15:0] rem_nx;

	always_comb begin
		rem2   = {rem_q, 1'b0};
		take   = rem2 >= {1'b0, divisor_q};
		rem_nx = take ? 16'(rem2 - {1'b0, divisor_q}) : rem2[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (op.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(FRAC_BITS + 1);
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// first step resolves the integer bit (dividend never exceeds divisor)
	always_ff @(posedge clk) begin
		if (op.start) begin
			divisor_q <= op.divisor;
			if (op.dividend >= op.divisor) begin
				rem_q  <= op.dividend - op.divisor;
				quot_q <= QW'(1);
			end else begin
				rem_q  <= op.dividend;
				quot_q <= '0;
			end
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			quot_q <= {quot_q[QW-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

[hw/rtl/channel_range_scaler_top.sv]
// Scale-input: the response passes the check, evaluate, serial divider and done states.
// Scale-output: table read, 18x17 multiply, offset add and clamp.
// Set, bad channel, unknown command skip evaluation; range or type errors stop after it.
// A new request is taken only once the previous response has been registered.
// Async reset clears the controller and all entry valid bits: tables read zero.
`default_nettype none

module channel_range_scaler_top import csc_pkg::*; #(
	parameter int CHANNELS  = 16,
	parameter int FRAC_BITS = 14
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       req_valid,
	output logic      req_ready,
	input  csc_in_t   req_data,
	output logic      rsp_valid,
	input  wire       rsp_ready,
	output csc_out_t  rsp_data
);

	localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int AW    = CH_AW + 1;
	localparam int DEPTH = 2 ** AW;
	localparam int QW    = FRAC_BITS + 2;
	localparam int PW    = 36;
	localparam logic signed [17:0] ONE_A = 18'(2 ** FRAC_BITS);
	localparam logic signed [QW:0] ONE_Q = (QW + 1)'(2 ** FRAC_BITS);

	csc_state_t state_q, state_d;

	csc_in_t    req_q;
	csc_out_t   res_q;
	csc_out_t   rsp_q;
	logic       rsp_valid_q;

	logic [DEPTH-1:0] ent_vld_q;
	logic             rd_vld_q;

	logic [CH_AW-1:0] ch_idx;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic             bad_ch;
	logic             mem_we;
	csc_ent_t         wr_ent;
	csc_ent_t         rd_ent;
	csc_ent_t         ent;

	logic                 type_ok;
	logic                 span_zero;
	logic                 out_of_range;
	logic [1:0]           eval_status;
	logic                 rsp_load;
	csc_div_op_t          div_op;
	logic                 div_done;
	logic [QW-1:0]        div_quot;

	logic [1:0]           ty_q;
	logic [15:0]          mn_q;
	logic signed [16:0]   span_q;
	logic signed [17:0]   mul_a;
	logic signed [34:0]   prod_q;
	logic signed [PW-1:0] offs_w;
	logic signed [PW-1:0] sum_w;
	logic signed [PW-1:0] shr_w;
	logic [15:0]          pulse_w;
	logic signed [QW:0]   bip_w;
	logic signed [15:0]   norm_w;

	assign ch_idx = CH_AW'(req_q.channel);
	assign bad_ch = 32'(req_q.channel) >= 32'(CHANNELS);
	assign waddr  = {req_q.table_sel, ch_idx};
	assign raddr  = {req_q.cmd == CMD_SCALE_OUT, ch_idx};
	assign wr_ent = '{ty: req_q.new_type, mn: req_q.new_min, mx: req_q.new_max};
	assign ent    = rd_vld_q ? rd_ent : '0;

	csc_ram #(
		.WIDTH($bits(csc_ent_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(waddr),
		.wdata(wr_ent),
		.raddr(raddr),
		.rdata(rd_ent)
	);

	csc_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (div_op),
		.done  (div_done),
		.quot  (div_quot)
	);

	// range entry checks
	always_comb begin
		type_ok      = (ent.ty == TY_UNI) || (ent.ty == TY_BI);
		span_zero    = ent.mx == ent.mn;
		out_of_range = (req_q.pulse_in < ent.mn) || (req_q.pulse_in > ent.mx);
		if (req_q.cmd == CMD_SCALE_OUT) begin
			if (!type_ok) begin
				eval_status = ST_TYPE;
			end else if (span_zero) begin
				eval_status = ST_RANGE;
			end else begin
				eval_status = ST_OK;
			end
		end else begin
			if (out_of_range || span_zero) begin
				eval_status = ST_RANGE;
			end else if (!type_ok) begin
				eval_status = ST_TYPE;
			end else begin
				eval_status = ST_OK;
			end
		end
	end

	// unipolar doubles the demand so both kinds share the F+1 shift
	always_comb begin
		mul_a   = (ty_q == TY_UNI) ? (18'(req_q.norm_value) <<< 1)
		                           : (18'(req_q.norm_value) + ONE_A);
		offs_w  = PW'(mn_q) << (FRAC_BITS + 1);
		sum_w   = PW'(prod_q) + offs_w;
		shr_w   = sum_w >>> (FRAC_BITS + 1);
		if (sum_w[PW-1]) begin
			pulse_w = '0;
		end else if (shr_w[PW-2:16] != '0) begin
			pulse_w = 16'hFFFF;
		end else begin
			pulse_w = shr_w[15:0];
		end
		bip_w  = $signed({1'b0, div_quot}) - ONE_Q;
		norm_w = (ty_q == TY_UNI) ? 16'(div_quot >> 1) : 16'(bip_w);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if ((req_q.cmd == CMD_SCALE_OUT || req_q.cmd == CMD_SCALE_IN) && !bad_ch)
					state_d = S_EVAL;
				else
					state_d = S_DONE;
			end
			S_EVAL: begin
				if (eval_status != ST_OK)
					state_d = S_DONE;
				else if (req_q.cmd == CMD_SCALE_OUT)
					state_d = S_MUL;
				else
					state_d = S_DIV;
			end
			S_MUL:  state_d = S_SUM;
			S_SUM:  state_d = S_DONE;
			S_DIV: begin
				if (div_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready       = state_q == S_IDLE;
		mem_we          = (state_q == S_CHECK) && (req_q.cmd == CMD_SET) && !bad_ch;
		rsp_load        = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
		div_op.start    = (state_q == S_EVAL) && (req_q.cmd == CMD_SCALE_IN)
		                  && (eval_status == ST_OK);
		div_op.dividend = req_q.pulse_in - ent.mn;
		div_op.divisor  = ent.mx - ent.mn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			ent_vld_q   <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= ent_vld_q[raddr];
			if (mem_we) ent_vld_q[waddr] <= 1'b1;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) req_q <= req_data;
		if (rsp_load) rsp_q <= res_q;
		if (state_q == S_MUL) prod_q <= mul_a * span_q;
		case (state_q)
			S_CHECK: begin
				res_q.pulse_out <= '0;
				res_q.norm_out  <= '0;
				res_q.status    <= (req_q.cmd != CMD_NONE && bad_ch) ? ST_BAD_CHAN : ST_OK;
			end
			S_EVAL: begin
				ty_q         <= ent.ty;
				mn_q         <= ent.mn;
				span_q       <= $signed({1'b0, ent.mx}) - $signed({1'b0, ent.mn});
				res_q.status <= eval_status;
			end
			S_SUM: begin
				res_q.pulse_out <= pulse_w;
			end
			S_DIV: begin
				if (div_done) res_q.norm_out <= norm_w;
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

`default_nettype wire

[hw/rtl/csc_checker.sv]
// Port-level checks for the channel range scaler, bound to the top level.
// Depends on csc_pkg and channel_range_scaler_top.
`default_nettype none

module csc_checker import csc_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input wire      clk,
	input wire      arst_n,
	input wire      req_valid,
	input wire      req_ready,
	input wire      rsp_valid,
	input wire      rsp_ready,
	input csc_out_t rsp_data
);

	localparam logic signed [15:0] ONE = 16'(2 ** FRAC_BITS);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response dropped or changed while stalled");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in flight");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |->
		rsp_data.pulse_out == '0 && rsp_data.norm_out == '0)
		else $error("nonzero result with error status");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.pulse_out == '0 || rsp_data.norm_out == '0)
		else $error("pulse and normalized results both set");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.norm_out <= ONE && rsp_data.norm_out >= -ONE)
		else $error("normalized result beyond full scale");

endmodule

bind channel_range_scaler_top csc_checker #(
	.FRAC_BITS(FRAC_BITS)
) u_csc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp_data (rsp_data)
);

`default_nettype wire

[dv/tb_channel_range_scaler_top.sv]
// Testbench for channel_range_scaler_top: drives set/scale requests over valid/ready,
// predicts every response from its own copy of both range tables and checks it.
// Depends on csc_pkg and channel_range_scaler_top.
`timescale 1ns / 1ps

module tb_channel_range_scaler_top;
	import csc_pkg::*;

	localparam int N_CHAN      = 16;
	localparam int FRAC_BITS   = 14;
	localparam int ONE         = 1 << FRAC_BITS;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	csc_in_t  req_data  = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	csc_out_t rsp_data;

	csc_ent_t rng_tab [2][N_CHAN];
	csc_out_t exp_scaled_q[$];
	int       err_cnt = 0;
	int       stall_cycles = 0;
	bit       req_idle_en = 1'b1;
	bit       rsp_idle_en = 1'b1;
	bit       hold_start = 1'b0;
	int       hold_left = 0;
	int       gap_left = 0;

	channel_range_scaler_top #(
		.CHANNELS (N_CHAN),
		.FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	always #2 clk = ~clk;

	// Expected response for one request; updates the range tables on a set.
	function automatic csc_out_t predict_scaling(csc_in_t rq);
		csc_out_t r;
		csc_ent_t e;
		longint   one, mn, mx, span, norm, pin, num, q;
		int       sh;
		r = '0;
		one = longint'(ONE);
		norm = longint'($signed(rq.norm_value));
		pin = longint'(rq.pulse_in);
		if (rq.cmd != CMD_NONE && int'(rq.channel) >= N_CHAN) begin
			r.status = ST_BAD_CHAN;
			return r;
		end
		case (rq.cmd)
			CMD_SET: begin
				e.ty = rq.new_type;
				e.mn = rq.new_min;
				e.mx = rq.new_max;
				rng_tab[rq.table_sel][rq.channel] = e;
			end
			CMD_SCALE_OUT: begin
				e = rng_tab[1][rq.channel];
				mn = longint'(e.mn);
				span = longint'(e.mx) - mn;
				if (e.ty != TY_UNI && e.ty != TY_BI) begin
					r.status = ST_TYPE;
				end else if (span == 0) begin
					r.status = ST_RANGE;
				end else begin
					if (e.ty == TY_UNI) begin
						num = norm * span + mn * one;
						sh = FRAC_BITS;
					end else begin
						num = (norm + one) * span + mn * 2 * one;
						sh = FRAC_BITS + 1;
					end
					if (num < 0)
						q = 0;
					else
						q = num >>> sh;
					if (q > 65535)
						q = 65535;
					r.pulse_out = q[15:0];
				end
			end
			CMD_SCALE_IN: begin
				e = rng_tab[0][rq.channel];
				mn = longint'(e.mn);
				mx = longint'(e.mx);
				span = mx - mn;
				if (pin < mn || pin > mx || span == 0) begin
					r.status = ST_RANGE;
				end else if (e.ty == TY_UNI) begin
					q = ((pin - mn) * one) / span;
					if (q > one)
						q = one;
					if (q < 0)
						q = 0;
					r.norm_out = q[15:0];
				end else if (e.ty == TY_BI) begin
					q = (2 * (pin - mn) * one) / span - one;
					if (q > one)
						q = one;
					if (q < -one)
						q = -one;
					r.norm_out = q[15:0];
				end else begin
					r.status = ST_TYPE;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic csc_in_t rand_req();
		csc_in_t rq;
		rq.cmd        = 2'($urandom_range(0, 3));
		rq.table_sel  = 1'($urandom_range(0, 1));
		rq.channel    = 4'($urandom_range(0, 15));
		rq.new_type   = 2'($urandom_range(0, 3));
		rq.new_min    = 16'($urandom);
		rq.new_max    = 16'($urandom);
		rq.norm_value = 16'($urandom);
		rq.pulse_in   = 16'($urandom);
		return rq;
	endfunction

	function automatic csc_in_t mk_set(bit tsel, int ch, logic [1:0] ty, int mn, int mx);
		csc_in_t rq;
		rq = rand_req();
		rq.cmd = CMD_SET;
		rq.table_sel = tsel;
		rq.channel = 4'(ch);
		rq.new_type = ty;
		rq.new_min = 16'(mn);
		rq.new_max = 16'(mx);
		return rq;
	endfunction

	function automatic csc_in_t mk_scale(logic [1:0] cmd, int ch, int val);
		csc_in_t rq;
		rq = rand_req();
		rq.cmd = cmd;
		rq.channel = 4'(ch);
		if (cmd == CMD_SCALE_OUT)
			rq.norm_value = 16'(val);
		else
			rq.pulse_in = 16'(val);
		return rq;
	endfunction

	// Mostly realistic ranges and in-range values, with some noise.
	function automatic csc_in_t gen_mixed_req();
		csc_in_t  rq;
		csc_ent_t e;
		int       sel, k, lo, hi, v;
		rq = rand_req();
		sel = $urandom_range(0, 99);
		if (sel < 20) begin
			rq.cmd = CMD_SET;
			k = $urandom_range(0, 9);
			lo = $urandom_range(500, 1500);
			hi = lo + $urandom_range(1, 1500);
			if (k < 6) begin
				rq.new_min = 16'(lo);
				rq.new_max = 16'(hi);
			end else if (k == 6) begin
				rq.new_min = 16'(lo);
				rq.new_max = 16'(lo);
			end else if (k == 7) begin
				rq.new_min = 16'(hi);
				rq.new_max = 16'(lo);
			end else if (k == 8) begin
				rq.new_min = 16'h0000;
				rq.new_max = 16'hffff;
			end
			if ($urandom_range(0, 4) != 0)
				rq.new_type = ($urandom_range(0, 1) != 0) ? TY_UNI : TY_BI;
		end else if (sel < 55) begin
			rq.cmd = CMD_SCALE_OUT;
			if ($urandom_range(0, 9) < 7) begin
				v = int'($urandom_range(0, 2 * ONE + ONE / 4)) - (ONE + ONE / 8);
				rq.norm_value = 16'(v);
			end
		end else if (sel < 92) begin
			rq.cmd = CMD_SCALE_IN;
			e = rng_tab[0][rq.channel];
			k = $urandom_range(0, 19);
			if (k < 14)
				rq.pulse_in = 16'($urandom_range(e.mn, e.mx));
			else if (k == 14)
				rq.pulse_in = e.mn - 16'd1;
			else if (k == 15)
				rq.pulse_in = e.mx + 16'd1;
			else if (k == 16)
				rq.pulse_in = e.mn;
			else if (k == 17)
				rq.pulse_in = e.mx;
		end else begin
			rq.cmd = CMD_NONE;
		end
		return rq;
	endfunction

	task automatic send_req(input csc_in_t rq);
		if (req_idle_en && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= rq;
		do @(posedge clk); while (!req_ready);
		exp_scaled_q.push_back(predict_scaling(rq));
	endtask

	task automatic test_range_setup();
		send_req(mk_set(1'b1, 0, TY_UNI, 1000, 2000));
		send_req(mk_set(1'b1, 1, TY_BI, 1000, 2000));
		send_req(mk_set(1'b1, 2, TY_UNI, 0, 65535));
		send_req(mk_set(1'b1, 3, TY_UNI, 1500, 1500));
		send_req(mk_set(1'b1, 4, 2'd3, 1000, 2000));
		send_req(mk_set(1'b0, 0, TY_UNI, 1000, 2000));
		send_req(mk_set(1'b0, 1, TY_BI, 1000, 2000));
		send_req(mk_set(1'b0, 2, TY_BI, 2000, 1000));
	endtask

	task automatic test_scale_out_limits();
		send_req(mk_scale(CMD_SCALE_OUT, 0, 0));
		send_req(mk_scale(CMD_SCALE_OUT, 0, ONE));
		send_req(mk_scale(CMD_SCALE_OUT, 0, -32768));
		send_req(mk_scale(CMD_SCALE_OUT, 1, -ONE));
		send_req(mk_scale(CMD_SCALE_OUT, 2, 32767));
		send_req(mk_scale(CMD_SCALE_OUT, 3, ONE / 2));
		send_req(mk_scale(CMD_SCALE_OUT, 4, ONE / 2));
		send_req(mk_scale(CMD_SCALE_OUT, 15, ONE / 2));
	endtask

	task automatic test_scale_in_limits();
		send_req(mk_scale(CMD_SCALE_IN, 0, 1000));
		send_req(mk_scale(CMD_SCALE_IN, 0, 2000));
		send_req(mk_scale(CMD_SCALE_IN, 0, 999));
		send_req(mk_scale(CMD_SCALE_IN, 0, 2001));
		send_req(mk_scale(CMD_SCALE_IN, 1, 1500));
		send_req(mk_scale(CMD_SCALE_IN, 2, 1500));
		send_req(mk_scale(CMD_SCALE_IN, 3, 0));
		send_req(mk_scale(CMD_SCALE_IN, 15, 65535));
	endtask

	task automatic test_unused_cmd();
		csc_in_t rq;
		rq = rand_req();
		rq.cmd = CMD_NONE;
		send_req(rq);
	endtask

	task automatic test_random_mix(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0) begin
				req_idle_en = ($urandom_range(0, 2) != 0);
				rsp_idle_en = ($urandom_range(0, 2) != 0);
			end
			send_req(gen_mixed_req());
		end
	endtask

	// Receiver holds off while requests keep coming, so the block backs up.
	task automatic test_output_backpressure();
		req_idle_en = 1'b0;
		hold_start = 1'b1;
		for (int i = 0; i < 60; i++)
			send_req(gen_mixed_req());
	endtask

	task automatic test_steady_stream(input int n);
		req_idle_en = 1'b0;
		rsp_idle_en = 1'b0;
		for (int i = 0; i < n; i++)
			send_req(gen_mixed_req());
	endtask

	always @(posedge clk) begin
		if (hold_left == 0 && hold_start) begin
			hold_start = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left == 0 && gap_left == 0 && rsp_idle_en && $urandom_range(0, 3) == 0)
			gap_left = $urandom_range(1, 9);
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		csc_out_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (exp_scaled_q.size() == 0) begin
				$display("%0t: unexpected response, expected none, got %h", $time, rsp_data);
				err_cnt++;
			end else begin
				want = exp_scaled_q.pop_front();
				if (rsp_data.pulse_out !== want.pulse_out) begin
					$display("%0t: pulse_out expected %0d got %0d", $time,
						want.pulse_out, rsp_data.pulse_out);
					err_cnt++;
				end
				if (rsp_data.norm_out !== want.norm_out) begin
					$display("%0t: norm_out expected %0d got %0d", $time,
						want.norm_out, rsp_data.norm_out);
					err_cnt++;
				end
				if (rsp_data.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, rsp_data.status);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		for (int t = 0; t < 2; t++)
			for (int c = 0; c < N_CHAN; c++)
				rng_tab[t][c] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_range_setup();
		test_scale_out_limits();
		test_scale_in_limits();
		test_unused_cmd();
		test_random_mix(600);
		test_output_backpressure();
		test_steady_stream(80);
		req_valid <= 1'b0;
		while (exp_scaled_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
hw/rtl/csc_pkg.sv
hw/rtl/csc_ram.sv
hw/rtl/csc_div.sv
hw/rtl/channel_range_scaler_top.sv
hw/rtl/csc_checker.sv
dv/tb_channel_range_scaler_top.sv
